// File: hdl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Small set of assertion macros shared by the RTL files.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/css_pkg.sv
// ============================================================================
// css_pkg
// Types and constants of the clocked step sequencer.
// ============================================================================
package css_pkg;

    localparam int TABLE_TICKS    = 768;
    localparam int PATTERN_STEPS  = 128;
    localparam int TICKS_PER_BEAT = 24;
    localparam int SLOTS          = 16;
    localparam int MAX_OUT        = 16;

    localparam logic [2:0] REQ_CLOCK = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_OTHER = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;
    localparam logic [2:0] REQ_LOAD  = 3'd5;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_ON      = 2'd1;
    localparam logic [1:0] KIND_OFF     = 2'd2;
    localparam logic [1:0] KIND_ALL_OFF = 2'd3;

    localparam logic [0:0] REG_CLOCK_DELAY = 1'd0;
    localparam logic [0:0] REG_TRACK_MUTES = 1'd1;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [2:0]        track;
        logic [6:0]        pitch;
        logic [6:0]        step_index;
        logic [3:0]        step_velocity;
        logic [7:0]        step_duration;
        logic signed [7:0] step_drift;
        logic              last_step;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] out_track;
        logic [6:0] out_pitch;
        logic [6:0] out_velocity;
        logic       bar_mark;
        logic       last;
    } t_result;

    // Event word in the store: on flag, track, pitch, velocity.
    typedef struct packed {
        logic       on;
        logic [2:0] trk;
        logic [6:0] pit;
        logic [6:0] vel;
    } t_event;

    // Velocity scale, 4 bits to 7 bits: v * 127 / 15, truncated.
    function automatic logic [6:0] scale_vel(input logic [3:0] v);
        logic [6:0] q;
        case (v)
            4'd0:    q = 7'd0;
            4'd1:    q = 7'd8;
            4'd2:    q = 7'd16;
            4'd3:    q = 7'd25;
            4'd4:    q = 7'd33;
            4'd5:    q = 7'd42;
            4'd6:    q = 7'd50;
            4'd7:    q = 7'd59;
            4'd8:    q = 7'd67;
            4'd9:    q = 7'd76;
            4'd10:   q = 7'd84;
            4'd11:   q = 7'd93;
            4'd12:   q = 7'd101;
            4'd13:   q = 7'd110;
            4'd14:   q = 7'd118;
            default: q = 7'd127;
        endcase
        return q;
    endfunction

endpackage

// File: hdl/css_store.sv
// ============================================================================
// css_store
// Line count memory and event memory, both with registered read data.
// ============================================================================
module css_store #(
    parameter int TABLE_TICKS = css_pkg::TABLE_TICKS,
    parameter int SLOTS       = css_pkg::SLOTS,
    localparam int LW = $clog2(TABLE_TICKS),
    localparam int SW = $clog2(SLOTS),
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_cnt_we,
    input  logic [LW-1:0]          i_cnt_waddr,
    input  logic [CW-1:0]          i_cnt_wdata,
    input  logic [LW-1:0]          i_cnt_raddr,
    output logic [CW-1:0]          o_cnt_rdata,
    input  logic                   i_ev_we,
    input  logic [LW+SW-1:0]       i_ev_waddr,
    input  css_pkg::t_event        i_ev_wdata,
    input  logic [LW+SW-1:0]       i_ev_raddr,
    output css_pkg::t_event        o_ev_rdata
);

    logic [CW-1:0]   r_cnt_mem [TABLE_TICKS];
    css_pkg::t_event r_ev_mem  [TABLE_TICKS*SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_cnt_we) begin
            r_cnt_mem[i_cnt_waddr] <= i_cnt_wdata;
        end
        o_cnt_rdata <= r_cnt_mem[i_cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ev_we) begin
            r_ev_mem[i_ev_waddr] <= i_ev_wdata;
        end
        o_ev_rdata <= r_ev_mem[i_ev_raddr];
    end

endmodule

// File: hdl/clocked_step_sequencer_core.sv
// ============================================================================
// clocked_step_sequencer_core
// Tick-table drum step sequencer driven by MIDI clock requests.
// ============================================================================
// Usage: a request is taken when i_start is high and o_busy is low; its
// fields arrive as one packed struct on i_req. Results leave on o_result
// for one cycle each, flagged by o_valid, and the receiver cannot stall
// them; the last result of a request has its last bit set. Clear and load
// requests give no results. The configuration registers (clock delay,
// track mutes) are to be written over the APB port only while the block
// is idle; the block itself does not enforce this. Start, stop, other
// messages and clocks while stopped give their one result by way of the
// S_RESULT state, and the next request can be taken at the edge that ends
// the cycle in which that result is shown. A running clock reads the line
// count, then walks the line's events through the event memory, each
// stored event passing S_CLK_EV and S_CLK_OUT. A load writes up to four
// events, each through S_LOAD_NEXT, S_WR_RD, S_WR_WAIT and S_WR_DO. A
// clear sweeps the line count memory one line per cycle. After reset the
// same clearing pass runs with o_busy high before the first request is
// taken.
// ============================================================================
`include "assert_macros.svh"

module clocked_step_sequencer_core #(
    parameter int TABLE_TICKS    = css_pkg::TABLE_TICKS,
    parameter int PATTERN_STEPS  = css_pkg::PATTERN_STEPS,
    parameter int TICKS_PER_BEAT = css_pkg::TICKS_PER_BEAT,
    parameter int SLOTS          = css_pkg::SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  css_pkg::t_req     i_req,
    output logic              o_busy,
    output logic              o_valid,
    output css_pkg::t_result  o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:2]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int LW   = $clog2(TABLE_TICKS);
    localparam int SW   = $clog2(SLOTS);
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int M    = TABLE_TICKS / PATTERN_STEPS;
    localparam int BAR  = 4 * TICKS_PER_BEAT;
    localparam int PW   = 14;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RESULT, S_CLK_CNT, S_CLK_EV, S_CLK_OUT,
        S_WR_RD, S_WR_WAIT, S_WR_DO, S_LOAD_NEXT
    } t_state;

    t_state r_state;

    // Configuration.
    logic signed [10:0] r_delay;
    logic [7:0]         r_mutes;

    assign pready = 1'b1;
    always_comb begin
        if (paddr[2] == css_pkg::REG_TRACK_MUTES) begin
            prdata = {24'd0, r_mutes};
        end else begin
            prdata = {{21{r_delay[10]}}, r_delay};
        end
    end

    // Play state.
    logic [LW-1:0] r_tick;
    logic          r_running;

    // Pending note and the queue of events to write for a load.
    logic          r_pv;
    logic [LW-1:0] r_ps, r_pe;
    logic [6:0]    r_pvel, r_ppit;
    logic [2:0]    r_ptrk;

    css_pkg::t_event r_wq_ev  [4];
    logic [LW-1:0]   r_wq_line [4];
    logic [2:0]      r_wq_n;
    logic [2:0]      r_wq_i;

    // Clock walk. The newest unmuted event waits in r_hold until the walk
    // knows whether another one follows, so the final one can carry last.
    logic [LW-1:0]    r_line;
    logic             r_bar;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_idx;
    logic             r_any;
    css_pkg::t_result r_hold;

    // Memory ports.
    logic                 w_cnt_we;
    logic [LW-1:0]        w_cnt_waddr, w_cnt_raddr;
    logic [CW-1:0]        w_cnt_wdata, w_cnt_rdata;
    logic                 w_ev_we;
    logic [LW+SW-1:0]     w_ev_waddr, w_ev_raddr;
    css_pkg::t_event      w_ev_rdata;
    logic [LW-1:0]        r_clr;

    css_store #(.TABLE_TICKS(TABLE_TICKS), .SLOTS(SLOTS)) u_store (
        .i_clk       (i_clk),
        .i_cnt_we    (w_cnt_we),
        .i_cnt_waddr (w_cnt_waddr),
        .i_cnt_wdata (w_cnt_wdata),
        .i_cnt_raddr (w_cnt_raddr),
        .o_cnt_rdata (w_cnt_rdata),
        .i_ev_we     (w_ev_we),
        .i_ev_waddr  (w_ev_waddr),
        .i_ev_wdata  (r_wq_ev[r_wq_i[1:0]]),
        .i_ev_raddr  (w_ev_raddr),
        .o_ev_rdata  (w_ev_rdata)
    );

    wire w_accept = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE);

    // Line choice and bar test on the tick before this request, with no
    // divider: the sum is compared against each reachable positive multiple
    // of the table length and each reachable multiple of the bar length.
    logic signed [12:0] w_sum;
    logic signed [12:0] w_wrap;
    logic [LW-1:0]      w_line;
    logic               w_bar;
    always_comb begin
        w_sum  = 13'(signed'({1'b0, r_tick})) + 13'(r_delay);
        w_wrap = '0;
        for (int k = 1; k <= (TABLE_TICKS + 1023) / TABLE_TICKS; k++) begin
            if (w_sum >= 13'(k * TABLE_TICKS)) begin
                w_wrap = 13'(k * TABLE_TICKS);
            end
        end
        if (w_sum < 0) begin
            w_line = '0;
        end else begin
            w_line = LW'(w_sum - w_wrap);
        end
        w_bar = 1'b0;
        for (int k = -(1024 / BAR); k <= (TABLE_TICKS + 1023) / BAR; k++) begin
            if (w_sum == 13'(k * BAR)) begin
                w_bar = 1'b1;
            end
        end
    end

    // Load arithmetic.
    logic signed [PW-1:0] w_st_raw, w_en_raw;
    logic [LW-1:0]        w_st, w_en, w_pe_clip;
    always_comb begin
        w_st_raw = PW'(signed'({1'b0, i_req.step_index})) * PW'(M)
                 + PW'(i_req.step_drift) * PW'(M);
        if (w_st_raw < 0) begin
            w_st = '0;
        end else if (w_st_raw > PW'(TABLE_TICKS - 1)) begin
            w_st = LW'(TABLE_TICKS - 1);
        end else begin
            w_st = LW'(w_st_raw);
        end
        w_en_raw = PW'(signed'({1'b0, w_st})) + PW'(signed'({1'b0, i_req.step_duration}))
                 * PW'(M) - PW'(1);
        if (w_en_raw > PW'(TABLE_TICKS - 1)) begin
            w_en = LW'(TABLE_TICKS - 1);
        end else if (w_en_raw < PW'(signed'({1'b0, w_st}))) begin
            w_en = w_st;
        end else begin
            w_en = LW'(w_en_raw);
        end
        w_pe_clip = r_pe;
        if (r_ptrk == i_req.track && r_pe >= w_st) begin
            w_pe_clip = (w_st == '0 || (w_st - 1'b1) < r_ps) ? r_ps : w_st - 1'b1;
        end
    end

    logic [6:0] w_vel;
    assign w_vel = css_pkg::scale_vel(i_req.step_velocity);

    // Kind of the single result of a start, stop, other message or idle clock.
    logic [1:0] w_kind;
    assign w_kind = (i_req.req_type == css_pkg::REQ_STOP) ? css_pkg::KIND_ALL_OFF
                                                          : css_pkg::KIND_NONE;

    // Memory addressing.
    always_comb begin
        w_cnt_we    = 1'b0;
        w_cnt_waddr = r_wq_line[r_wq_i[1:0]];
        w_cnt_wdata = r_cnt + 1'b1;
        w_cnt_raddr = r_wq_line[r_wq_i[1:0]];
        w_ev_we     = 1'b0;
        w_ev_waddr  = {r_wq_line[r_wq_i[1:0]], r_cnt[SW-1:0]};
        w_ev_raddr  = {r_line, r_idx[SW-1:0]};
        case (r_state)
            S_CLEAR: begin
                w_cnt_we    = 1'b1;
                w_cnt_waddr = r_clr;
                w_cnt_wdata = '0;
            end
            S_IDLE: begin
                w_cnt_raddr = w_line;
            end
            S_WR_DO: begin
                w_cnt_we = (r_cnt < CW'(SLOTS));
                w_ev_we  = (r_cnt < CW'(SLOTS));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_delay   <= '0;
            r_mutes   <= '0;
            r_tick    <= '0;
            r_running <= 1'b0;
            r_pv      <= 1'b0;
            o_valid   <= 1'b0;
            r_wq_n    <= '0;
            r_wq_i    <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == css_pkg::REG_CLOCK_DELAY) begin
                    r_delay <= pwdata[10:0];
                end else begin
                    r_mutes <= pwdata[7:0];
                end
            end
            case (r_state)
                S_CLEAR: begin
                    o_valid <= 1'b0;
                    if (r_clr == LW'(TABLE_TICKS - 1)) begin
                        r_clr   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_clr   <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    o_valid <= 1'b0;
                    if (w_accept) begin
                        r_line <= w_line;
                        r_bar  <= w_bar;
                        o_result <= '{kind: w_kind, out_track: '0,
                                      out_pitch: '0, out_velocity: '0,
                                      bar_mark: w_bar, last: 1'b1};
                        case (i_req.req_type)
                            css_pkg::REQ_CLEAR: begin
                                r_pv    <= 1'b0;
                                r_state <= S_CLEAR;
                            end
                            css_pkg::REQ_START: begin
                                r_running <= 1'b1;
                                r_tick    <= '0;
                                r_state   <= S_RESULT;
                            end
                            css_pkg::REQ_STOP: begin
                                r_running     <= 1'b0;
                                r_tick        <= '0;
                                r_state       <= S_RESULT;
                            end
                            css_pkg::REQ_OTHER: begin
                                r_state <= S_RESULT;
                            end
                            css_pkg::REQ_CLOCK: begin
                                if (r_running) begin
                                    r_tick  <= (r_tick == LW'(TABLE_TICKS - 1)) ? '0
                                             : r_tick + 1'b1;
                                    r_idx   <= '0;
                                    r_any   <= 1'b0;
                                    r_state <= S_CLK_CNT;
                                end else begin
                                    r_state <= S_RESULT;
                                end
                            end
                            css_pkg::REQ_LOAD: begin : load
                                logic [2:0] n;
                                n = 3'd0;
                                if (i_req.step_velocity != 4'd0) begin
                                    if (r_pv) begin
                                        r_wq_line[0] <= r_ps;
                                        r_wq_ev[0]   <= '{1'b1, r_ptrk, r_ppit, r_pvel};
                                        r_wq_line[1] <= w_pe_clip;
                                        r_wq_ev[1]   <= '{1'b0, r_ptrk, r_ppit, r_pvel};
                                        n = 3'd2;
                                    end
                                    if (i_req.last_step) begin
                                        r_wq_line[n[1:0]]      <= w_st;
                                        r_wq_ev[n[1:0]]        <= '{1'b1, i_req.track,
                                                                   i_req.pitch, w_vel};
                                        r_wq_line[n[1:0]+2'd1] <= w_en;
                                        r_wq_ev[n[1:0]+2'd1]   <= '{1'b0, i_req.track,
                                                                   i_req.pitch, w_vel};
                                        n = n + 3'd2;
                                        r_pv <= 1'b0;
                                    end else begin
                                        r_pv <= 1'b1;
                                    end
                                    r_ps   <= w_st;
                                    r_pe   <= w_en;
                                    r_ptrk <= i_req.track;
                                    r_ppit <= i_req.pitch;
                                    r_pvel <= w_vel;
                                end else if (i_req.last_step && r_pv) begin
                                    r_wq_line[0] <= r_ps;
                                    r_wq_ev[0]   <= '{1'b1, r_ptrk, r_ppit, r_pvel};
                                    r_wq_line[1] <= r_pe;
                                    r_wq_ev[1]   <= '{1'b0, r_ptrk, r_ppit, r_pvel};
                                    n = 3'd2;
                                    r_pv <= 1'b0;
                                end
                                r_wq_n  <= n;
                                r_wq_i  <= '0;
                                r_state <= S_LOAD_NEXT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RESULT: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_CLK_CNT: begin
                    o_valid <= 1'b0;
                    r_cnt   <= w_cnt_rdata;
                    r_state <= S_CLK_EV;
                end
                S_CLK_EV: begin
                    // Event address is issued this cycle.
                    if (r_idx >= r_cnt) begin
                        if (!r_any) begin
                            o_result <= '{kind: css_pkg::KIND_NONE, out_track: '0,
                                          out_pitch: '0, out_velocity: '0,
                                          bar_mark: r_bar, last: 1'b1};
                        end else begin
                            // The held event is the final one of this clock.
                            o_result <= {r_hold[$bits(css_pkg::t_result)-1:1], 1'b1};
                        end
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        o_valid <= 1'b0;
                        r_state <= S_CLK_OUT;
                    end
                end
                S_CLK_OUT: begin
                    r_idx   <= r_idx + 1'b1;
                    o_valid <= r_any && !r_mutes[w_ev_rdata.trk];
                    if (!r_mutes[w_ev_rdata.trk]) begin
                        // Another event follows the held one, so send it on.
                        if (r_any) begin
                            o_result <= r_hold;
                        end
                        r_any  <= 1'b1;
                        r_hold <= '{kind: w_ev_rdata.on ? css_pkg::KIND_ON
                                                        : css_pkg::KIND_OFF,
                                    out_track: w_ev_rdata.trk,
                                    out_pitch: w_ev_rdata.pit,
                                    out_velocity: w_ev_rdata.vel,
                                    bar_mark: r_bar, last: 1'b0};
                    end
                    r_state <= S_CLK_EV;
                end
                S_LOAD_NEXT: begin
                    o_valid <= 1'b0;
                    if (r_wq_i == r_wq_n) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_WR_RD;
                    end
                end
                S_WR_RD: begin
                    o_valid <= 1'b0;
                    r_state <= S_WR_WAIT;
                end
                S_WR_WAIT: begin
                    o_valid <= 1'b0;
                    r_cnt   <= w_cnt_rdata;
                    r_state <= S_WR_DO;
                end
                S_WR_DO: begin
                    o_valid <= 1'b0;
                    r_wq_i  <= r_wq_i + 1'b1;
                    r_state <= S_LOAD_NEXT;
                end
                default: begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, o_busy, !w_accept)
    `ASSERT_NEXT(a_stop_all_off, i_clk, i_rst_n,
        w_accept && i_req.req_type == css_pkg::REQ_STOP,
        o_result.kind == css_pkg::KIND_ALL_OFF)
    `ASSERT_IMPL(a_queue_bound, i_clk, i_rst_n, 1'b1, r_wq_i <= r_wq_n)

endmodule
